FILE: rtl/core/slec_pkg.sv
// ----------------------------------------------------------------------------
// slec_pkg
// Shared constants, codes, result records and keymap of the text console.
// ----------------------------------------------------------------------------
package slec_pkg;

  localparam int SCREEN_ROWS    = 25;
  localparam int SCREEN_COLUMNS = 80;
  localparam int LINE_CAPACITY  = 64;

  localparam int KIND_W = 2;
  localparam int DATA_W = 8;
  localparam int IDX_W  = 6;
  localparam int OP_W   = 3;
  localparam int CROW_W = 5;
  localparam int CCOL_W = 7;
  localparam int VAL_W  = 8;

  localparam int ROW_W = $clog2(SCREEN_ROWS);
  localparam int COL_W = $clog2(SCREEN_COLUMNS + 1);
  localparam int LEN_W = $clog2(LINE_CAPACITY);
  localparam int CMP_W = (LEN_W > IDX_W) ? LEN_W : IDX_W;

  localparam int KEY_COUNT = 58;
  localparam int KEY_W     = 7;
  localparam int KEY_SLOTS = 2 ** KEY_W;
  localparam int BREAK_BIT = 7;

  localparam logic [DATA_W-1:0] CH_NONE  = 8'h00;
  localparam logic [DATA_W-1:0] CH_BS    = 8'h08;
  localparam logic [DATA_W-1:0] CH_LF    = 8'h0A;
  localparam logic [DATA_W-1:0] CH_SPACE = 8'h20;

  typedef enum logic [KIND_W-1:0] {
    KIND_SCAN,
    KIND_PRINT,
    KIND_CLEAR,
    KIND_READ
  } slec_kind_t;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE,
    OP_SCROLL,
    OP_CLEAR,
    OP_LINE_READY,
    OP_LINE_CHAR
  } slec_op_t;

  typedef struct packed {
    slec_op_t           op;
    logic [CROW_W-1:0]  row;
    logic [CCOL_W-1:0]  col;
    logic [VAL_W-1:0]   value;
    logic               last;
  } slec_res_t;

  typedef struct packed {
    logic [1:0] cnt;
    slec_res_t  r0;
    slec_res_t  r1;
  } slec_batch_t;

  function automatic slec_res_t mk_res(slec_op_t op, logic [CROW_W-1:0] row,
                                       logic [CCOL_W-1:0] col, logic [VAL_W-1:0] value);
    slec_res_t r;
    r.op    = op;
    r.row   = row;
    r.col   = col;
    r.value = value;
    r.last  = 1'b0;
    return r;
  endfunction

  // set-1 make code to character
  function automatic logic [DATA_W-1:0] key_char(logic [KEY_W-1:0] k);
    logic [DATA_W-1:0] c;
    unique case (k)
      7'd1:    c = 8'h1B;
      7'd2:    c = 8'h31;
      7'd3:    c = 8'h32;
      7'd4:    c = 8'h33;
      7'd5:    c = 8'h34;
      7'd6:    c = 8'h35;
      7'd7:    c = 8'h36;
      7'd8:    c = 8'h37;
      7'd9:    c = 8'h38;
      7'd10:   c = 8'h39;
      7'd11:   c = 8'h30;
      7'd12:   c = 8'h2D;
      7'd13:   c = 8'h3D;
      7'd14:   c = CH_BS;
      7'd15:   c = 8'h09;
      7'd16:   c = 8'h71;
      7'd17:   c = 8'h77;
      7'd18:   c = 8'h65;
      7'd19:   c = 8'h72;
      7'd20:   c = 8'h74;
      7'd21:   c = 8'h79;
      7'd22:   c = 8'h75;
      7'd23:   c = 8'h69;
      7'd24:   c = 8'h6F;
      7'd25:   c = 8'h70;
      7'd26:   c = 8'h5B;
      7'd27:   c = 8'h5D;
      7'd28:   c = CH_LF;
      7'd30:   c = 8'h61;
      7'd31:   c = 8'h73;
      7'd32:   c = 8'h64;
      7'd33:   c = 8'h66;
      7'd34:   c = 8'h67;
      7'd35:   c = 8'h68;
      7'd36:   c = 8'h6A;
      7'd37:   c = 8'h6B;
      7'd38:   c = 8'h6C;
      7'd39:   c = 8'h3B;
      7'd40:   c = 8'h27;
      7'd41:   c = 8'h60;
      7'd43:   c = 8'h5C;
      7'd44:   c = 8'h7A;
      7'd45:   c = 8'h78;
      7'd46:   c = 8'h63;
      7'd47:   c = 8'h76;
      7'd48:   c = 8'h62;
      7'd49:   c = 8'h6E;
      7'd50:   c = 8'h6D;
      7'd51:   c = 8'h2C;
      7'd52:   c = 8'h2E;
      7'd53:   c = 8'h2F;
      7'd57:   c = CH_SPACE;
      default: c = CH_NONE;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/core/slec_if.sv
// ----------------------------------------------------------------------------
// slec_in_if / slec_out_if
// Request and result channels of the text console, valid/ready handshake.
// ----------------------------------------------------------------------------
interface slec_in_if import slec_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [DATA_W-1:0] data;
  logic [IDX_W-1:0]  line_index;

  modport source (output valid, output kind, output data, output line_index, input ready);
  modport sink   (input valid, input kind, input data, input line_index, output ready);
endinterface

interface slec_out_if import slec_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [CROW_W-1:0] cell_row;
  logic [CCOL_W-1:0] cell_column;
  logic [VAL_W-1:0]  value;
  logic              last;

  modport source (output valid, output op, output cell_row, output cell_column,
                  output value, output last, input ready);
  modport sink   (input valid, input op, input cell_row, input cell_column,
                  input value, input last, output ready);
endinterface

FILE: rtl/core/slec_ram.sv
// ----------------------------------------------------------------------------
// slec_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module slec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/slec_engine.sv
// ----------------------------------------------------------------------------
// slec_engine
// Request register, console state and the single-pass request decode that
// yields up to two display commands per request.
// ----------------------------------------------------------------------------
module slec_engine import slec_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [KIND_W-1:0] in_kind,
  input  logic [DATA_W-1:0] in_data,
  input  logic [IDX_W-1:0]  in_line_index,
  input  logic              take,
  output logic              batch_valid,
  output slec_batch_t       batch
);

  logic              stg_v_r;
  slec_kind_t        stg_kind_r;
  logic [DATA_W-1:0] stg_data_r;
  logic [IDX_W-1:0]  stg_idx_r;
  logic              byp_v_r;
  logic [DATA_W-1:0] byp_data_r;

  logic [LEN_W-1:0]     len_r, len_nxt;
  logic [LEN_W-1:0]     fin_r, fin_nxt;
  logic [ROW_W-1:0]     row_r, row_nxt;
  logic [COL_W-1:0]     col_r, col_nxt;

  logic              clr_busy_r;
  logic [KEY_W-1:0]  clr_addr_r;
  logic              hbyp_v_r;
  logic              hbyp_bit_r;
  logic              held_we_req;
  logic              held_wbit;
  logic              held_we;
  logic [KEY_W-1:0]  held_waddr;
  logic              held_wdata;
  logic [KEY_W-1:0]  held_raddr;
  logic              held_rdata;
  logic              held_bit;

  logic              accept;
  logic              proc;
  logic              we_req;
  logic              ram_we;
  logic [LEN_W-1:0]  ram_raddr;
  logic [DATA_W-1:0] ram_rdata;
  logic [DATA_W-1:0] rd_char;
  logic              line_hit;

  logic [KEY_W-1:0]  key;
  logic [DATA_W-1:0] key_ch;
  logic              nr_wrap;
  logic [ROW_W-1:0]  nr_row;
  logic [DATA_W-1:0] put_ch;
  logic              put_wrap;
  logic [ROW_W-1:0]  put_row;
  logic [COL_W-1:0]  put_col;
  logic              do_put;
  logic              do_nl;
  logic              do_lr;
  slec_res_t         r0, r1;
  logic [1:0]        cnt;

  assign in_ready    = !clr_busy_r && (!stg_v_r || take);
  assign accept      = in_valid && in_ready;
  assign proc        = stg_v_r && take;
  assign batch_valid = proc;

  assign key      = stg_data_r[KEY_W-1:0];
  assign key_ch   = key_char(key);
  assign nr_wrap  = (row_r == ROW_W'(SCREEN_ROWS - 1));
  assign nr_row   = nr_wrap ? row_r : row_r + 1'b1;
  assign put_ch   = (stg_kind_r == KIND_SCAN) ? key_ch : stg_data_r;
  assign put_wrap = (col_r >= COL_W'(SCREEN_COLUMNS));
  assign put_row  = put_wrap ? nr_row : row_r;
  assign put_col  = put_wrap ? '0 : col_r;

  assign ram_we    = proc && we_req;
  assign ram_raddr = LEN_W'(in_line_index);
  assign rd_char   = byp_v_r ? byp_data_r : ram_rdata;
  assign line_hit  = (CMP_W'(stg_idx_r) < CMP_W'(fin_r));

  // key-held map, cleared by a pass after reset
  assign held_raddr = in_data[KEY_W-1:0];
  assign held_we    = clr_busy_r || (proc && held_we_req);
  assign held_waddr = clr_busy_r ? clr_addr_r : key;
  assign held_wdata = !clr_busy_r && held_wbit;
  assign held_bit   = hbyp_v_r ? hbyp_bit_r : held_rdata;

  slec_ram #(
    .WIDTH (DATA_W),
    .DEPTH (LINE_CAPACITY)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (len_r),
    .wdata (key_ch),
    .re    (accept),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  slec_ram #(
    .WIDTH (1),
    .DEPTH (KEY_SLOTS)
  ) u_held_ram (
    .clk   (clk),
    .we    (held_we),
    .waddr (held_waddr),
    .wdata (held_wdata),
    .re    (accept),
    .raddr (held_raddr),
    .rdata (held_rdata)
  );

  always_comb begin
    len_nxt     = len_r;
    fin_nxt     = fin_r;
    row_nxt     = row_r;
    col_nxt     = col_r;
    we_req      = 1'b0;
    held_we_req = 1'b0;
    held_wbit   = 1'b0;
    do_put      = 1'b0;
    do_nl       = 1'b0;
    do_lr       = 1'b0;
    cnt         = 2'd0;
    r0          = mk_res(OP_WRITE, '0, '0, '0);
    r1          = mk_res(OP_WRITE, '0, '0, '0);

    unique case (stg_kind_r)
      KIND_SCAN: begin
        if (stg_data_r[BREAK_BIT]) begin
          held_we_req = 1'b1;
          held_wbit   = 1'b0;
        end else if ((key < KEY_W'(KEY_COUNT)) && !held_bit) begin
          held_we_req = 1'b1;
          held_wbit   = 1'b1;
          if (key_ch == CH_BS) begin
            if ((len_r != '0) && (col_r != '0)) begin
              len_nxt = len_r - 1'b1;
              col_nxt = col_r - 1'b1;
              r0      = mk_res(OP_WRITE, CROW_W'(row_r), CCOL_W'(col_r - 1'b1), CH_SPACE);
              cnt     = 2'd1;
            end
          end else if (key_ch == CH_LF) begin
            fin_nxt = len_r;
            len_nxt = '0;
            do_nl   = 1'b1;
            do_lr   = 1'b1;
          end else if ((key_ch != CH_NONE) && (len_r < LEN_W'(LINE_CAPACITY - 1))) begin
            we_req  = 1'b1;
            len_nxt = len_r + 1'b1;
            do_put  = 1'b1;
          end
        end
      end
      KIND_PRINT: begin
        if (stg_data_r == CH_LF) begin
          do_nl = 1'b1;
        end else begin
          do_put = 1'b1;
        end
      end
      KIND_CLEAR: begin
        row_nxt = '0;
        col_nxt = '0;
        r0      = mk_res(OP_CLEAR, '0, '0, '0);
        cnt     = 2'd1;
      end
      KIND_READ: begin
        r0  = mk_res(OP_LINE_CHAR, '0, '0, line_hit ? rd_char : CH_NONE);
        cnt = 2'd1;
      end
    endcase

    if (do_put) begin
      row_nxt = put_row;
      col_nxt = put_col + 1'b1;
      if (put_wrap && nr_wrap) begin
        r0  = mk_res(OP_SCROLL, '0, '0, '0);
        r1  = mk_res(OP_WRITE, CROW_W'(put_row), CCOL_W'(put_col), put_ch);
        cnt = 2'd2;
      end else begin
        r0  = mk_res(OP_WRITE, CROW_W'(put_row), CCOL_W'(put_col), put_ch);
        cnt = 2'd1;
      end
    end

    if (do_nl) begin
      row_nxt = nr_row;
      col_nxt = '0;
      if (nr_wrap) begin
        r0 = mk_res(OP_SCROLL, '0, '0, '0);
        if (do_lr) begin
          r1  = mk_res(OP_LINE_READY, '0, '0, VAL_W'(len_r));
          cnt = 2'd2;
        end else begin
          cnt = 2'd1;
        end
      end else if (do_lr) begin
        r0  = mk_res(OP_LINE_READY, '0, '0, VAL_W'(len_r));
        cnt = 2'd1;
      end
    end

    if (cnt == 2'd1) begin
      r0.last = 1'b1;
    end else if (cnt == 2'd2) begin
      r1.last = 1'b1;
    end

    batch.cnt = cnt;
    batch.r0  = r0;
    batch.r1  = r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r    <= 1'b0;
      byp_v_r    <= 1'b0;
      hbyp_v_r   <= 1'b0;
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
      len_r      <= '0;
      fin_r      <= '0;
      row_r      <= '0;
      col_r      <= '0;
    end else begin
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == KEY_W'(KEY_SLOTS - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
      if (accept) begin
        stg_v_r  <= 1'b1;
        byp_v_r  <= ram_we && (len_r == ram_raddr);
        hbyp_v_r <= proc && held_we_req && (key == held_raddr);
      end else if (proc) begin
        stg_v_r <= 1'b0;
      end
      if (proc) begin
        len_r  <= len_nxt;
        fin_r  <= fin_nxt;
        row_r  <= row_nxt;
        col_r  <= col_nxt;
      end
    end
  end

  // request payload and same-cycle write forwarding
  always_ff @(posedge clk) begin
    if (accept) begin
      stg_kind_r <= slec_kind_t'(in_kind);
      stg_data_r <= in_data;
      stg_idx_r  <= in_line_index;
      byp_data_r <= key_ch;
      hbyp_bit_r <= held_wbit;
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (len_r < LEN_W'(LINE_CAPACITY - 1)))
    else $error("line store written past capacity");

  a_clear_home: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && (stg_kind_r == KIND_CLEAR)) |=> ((row_r == '0) && (col_r == '0)))
    else $error("clear did not home the cursor");

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    proc |=> (row_r < ROW_W'(SCREEN_ROWS)))
    else $error("cursor row beyond last screen row");

  a_clear_pass_idle: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> (!in_ready && !stg_v_r))
    else $error("request taken during key map clearing");

endmodule

FILE: rtl/core/slec_outbuf.sv
// ----------------------------------------------------------------------------
// slec_outbuf
// Two-entry result register that delivers a request's commands one by one.
// ----------------------------------------------------------------------------
module slec_outbuf import slec_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  slec_batch_t batch,
  output logic        can_take,
  output logic        out_valid,
  input  logic        out_ready,
  output slec_res_t   out_res
);

  logic [1:0] cnt_r, cnt_nxt;
  slec_res_t  s0_r, s0_nxt;
  slec_res_t  s1_r, s1_nxt;

  assign out_valid = (cnt_r != 2'd0);
  assign out_res   = s0_r;
  assign can_take  = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);

  always_comb begin
    cnt_nxt = cnt_r;
    s0_nxt  = s0_r;
    s1_nxt  = s1_r;
    if (load) begin
      cnt_nxt = batch.cnt;
      s0_nxt  = batch.r0;
      s1_nxt  = batch.r1;
    end else if (out_valid && out_ready) begin
      cnt_nxt = cnt_r - 1'b1;
      s0_nxt  = s1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s0_r <= s0_nxt;
    s1_r <= s1_nxt;
  end

  a_pair_head: assert property (@(posedge clk) disable iff (!rst_n)
    (load && (batch.cnt == 2'd2)) |=> ((cnt_r == 2'd2) && !out_res.last))
    else $error("first of two commands flagged as last");

endmodule

FILE: rtl/core/scancode_line_editor_console.sv
// ----------------------------------------------------------------------------
// scancode_line_editor_console
// PS/2 set-1 keyboard text console with a one-line editor.
// ----------------------------------------------------------------------------
// Takes one request per clock while the result side keeps up: a request is
// registered, decoded in one pass against the console state, and its
// commands are loaded into a two-entry result register once it can take
// them. Requests that give two commands (scroll then write, or scroll then
// line ready) hold the result port for both commands, and the next request
// waits until the register can take its commands. Finished-line reads and
// key-held lookups go through the registered read ports of their stores, so
// no extra latency is added. After reset the key-held map is cleared by a
// pass over every entry, during which in_ready stays low. The line store
// needs no such pass: never-written line entries are never read.
module scancode_line_editor_console import slec_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  slec_in_if.sink   in_ch,
  slec_out_if.source out_ch
);

  logic        take;
  logic        batch_valid;
  slec_batch_t batch;
  slec_res_t   res;

  slec_engine u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_kind       (in_ch.kind),
    .in_data       (in_ch.data),
    .in_line_index (in_ch.line_index),
    .take          (take),
    .batch_valid   (batch_valid),
    .batch         (batch)
  );

  slec_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (batch_valid),
    .batch     (batch),
    .can_take  (take),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (res)
  );

  assign out_ch.op          = res.op;
  assign out_ch.cell_row    = res.row;
  assign out_ch.cell_column = res.col;
  assign out_ch.value       = res.value;
  assign out_ch.last        = res.last;

endmodule

FILE: sim/scancode_line_editor_console_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scancode_line_editor_console_tb
// Self-checking bench for the keyboard text console: directed key, print,
// clear and line-read requests, a full-line and screen-scroll workout, then
// random typing traffic under bursty input and stalling output, each display
// command compared with an in-bench model of the console.
// ----------------------------------------------------------------------------
module scancode_line_editor_console_tb;
  import slec_pkg::*;

  localparam int SETTLE_CYCLES = 10;
  localparam int IDX_MAX       = 2 ** IDX_W - 1;

  localparam logic [DATA_W-1:0] RELEASE_FLAG = DATA_W'(1 << BREAK_BIT);
  localparam logic [DATA_W-1:0] SC_ESC       = 8'h01;
  localparam logic [DATA_W-1:0] SC_BACKSPACE = 8'h0E;
  localparam logic [DATA_W-1:0] SC_Q         = 8'h10;
  localparam logic [DATA_W-1:0] SC_ENTER     = 8'h1C;
  localparam logic [DATA_W-1:0] SC_CTRL      = 8'h1D;
  localparam logic [DATA_W-1:0] SC_A         = 8'h1E;
  localparam logic [DATA_W-1:0] SC_SPACE     = 8'h39;
  localparam logic [DATA_W-1:0] SC_UNMAPPED  = 8'h3A;
  localparam logic [DATA_W-1:0] SC_TOP_MAKE  = 8'h7F;
  localparam logic [DATA_W-1:0] SC_TOP_BREAK = 8'hFF;

  logic clk;
  logic rst_n;

  slec_in_if  in_ch();
  slec_out_if out_ch();

  scancode_line_editor_console uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // set-1 keymap, make code to character
  logic [DATA_W-1:0] key_map [KEY_COUNT] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
    8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
    8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
    8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
    8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h00, 8'h00, 8'h20
  };

  logic [KEY_SLOTS-1:0] held_keys;
  logic [DATA_W-1:0]    typed_line [LINE_CAPACITY];
  int                   line_len;
  int                   done_len;
  int                   cur_row;
  int                   cur_col;

  slec_res_t new_cmds [$];
  slec_res_t cmds_due [$];

  int         errors;
  int         sent;
  int         burst_left;
  logic [6:0] stall_phase = '0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [DATA_W-1:0] rnd_data();
    return DATA_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [IDX_W-1:0] rnd_idx();
    return IDX_W'($urandom_range(0, IDX_MAX));
  endfunction

  // ---- console model ----

  function automatic void add_cmd(slec_op_t op, int r, int c, int v);
    slec_res_t cmd;
    cmd.op    = op;
    cmd.row   = r[CROW_W-1:0];
    cmd.col   = c[CCOL_W-1:0];
    cmd.value = v[VAL_W-1:0];
    cmd.last  = 1'b0;
    new_cmds.push_back(cmd);
  endfunction

  function automatic void advance_row();
    cur_col = 0;
    cur_row++;
    if (cur_row >= SCREEN_ROWS) begin
      cur_row = SCREEN_ROWS - 1;
      add_cmd(OP_SCROLL, 0, 0, 0);
    end
  endfunction

  function automatic void echo_char(logic [DATA_W-1:0] ch);
    if (ch == CH_LF) begin
      advance_row();
    end else begin
      if (cur_col >= SCREEN_COLUMNS) advance_row();
      add_cmd(OP_WRITE, cur_row, cur_col, ch);
      cur_col++;
    end
  endfunction

  function automatic void key_event(logic [DATA_W-1:0] code);
    logic [KEY_W-1:0]  k;
    logic [DATA_W-1:0] ch;
    k = code[KEY_W-1:0];
    if (code[BREAK_BIT]) begin
      held_keys[k] = 1'b0;
    end else if (k < KEY_COUNT && !held_keys[k]) begin
      held_keys[k] = 1'b1;
      ch = key_map[k];
      if (ch == CH_BS) begin
        if (line_len > 0 && cur_col > 0) begin
          line_len--;
          cur_col--;
          add_cmd(OP_WRITE, cur_row, cur_col, CH_SPACE);
        end
      end else if (ch == CH_LF) begin
        done_len = line_len;
        line_len = 0;
        advance_row();
        add_cmd(OP_LINE_READY, 0, 0, done_len);
      end else if (ch != CH_NONE && line_len < LINE_CAPACITY - 1) begin
        typed_line[line_len] = ch;
        line_len++;
        echo_char(ch);
      end
    end
  endfunction

  function automatic void predict_commands(slec_kind_t kind, logic [DATA_W-1:0] data,
                                           logic [IDX_W-1:0] idx);
    slec_res_t cmd;
    new_cmds.delete();
    case (kind)
      KIND_SCAN:  key_event(data);
      KIND_PRINT: echo_char(data);
      KIND_CLEAR: begin
        cur_row = 0;
        cur_col = 0;
        add_cmd(OP_CLEAR, 0, 0, 0);
      end
      default: add_cmd(OP_LINE_CHAR, 0, 0, (idx < done_len) ? typed_line[idx] : 8'h00);
    endcase
    if (new_cmds.size() > 0) begin
      cmd = new_cmds.pop_back();
      cmd.last = 1'b1;
      new_cmds.push_back(cmd);
    end
    foreach (new_cmds[i]) cmds_due.push_back(new_cmds[i]);
  endfunction

  // ---- request side ----

  task automatic send_req(slec_kind_t kind, logic [DATA_W-1:0] data, logic [IDX_W-1:0] idx);
    int gap;
    @(negedge clk);
    in_ch.valid      = 1'b1;
    in_ch.kind       = kind;
    in_ch.data       = data;
    in_ch.line_index = idx;
    do @(posedge clk); while (!in_ch.ready);
    predict_commands(kind, data, idx);
    sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = $urandom_range(0, 24);
    end
  endtask

  task automatic type_key(logic [DATA_W-1:0] code);
    send_req(KIND_SCAN, code, rnd_idx());
    send_req(KIND_SCAN, code | RELEASE_FLAG, rnd_idx());
  endtask

  function automatic logic [DATA_W-1:0] pick_key();
    int k;
    do k = $urandom_range(1, KEY_COUNT - 1);
    while (key_map[k] == CH_NONE || key_map[k] == CH_BS || key_map[k] == CH_LF);
    return DATA_W'(k);
  endfunction

  // ---- result side ----

  always @(negedge clk) begin
    stall_phase = stall_phase + 1'b1;
    case (stall_phase[6:5])
      2'd0:    out_ch.ready = 1'b1;
      2'd1:    out_ch.ready = ($urandom_range(0, 3) != 0);
      2'd2:    out_ch.ready = (stall_phase[3:0] < 4'd10);
      default: out_ch.ready = 1'($urandom_range(0, 1));
    endcase
  end

  function automatic void check_field(string name, logic [VAL_W-1:0] expv,
                                      logic [VAL_W-1:0] gotv);
    if (gotv !== expv) begin
      errors++;
      $error("%s expected %0d got %0d", name, expv, gotv);
    end
  endfunction

  always @(posedge clk) begin
    slec_res_t exp_cmd;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (cmds_due.size() == 0) begin
        errors++;
        $error("op expected none got %0d", out_ch.op);
      end else begin
        exp_cmd = cmds_due.pop_front();
        check_field("op", VAL_W'(exp_cmd.op), VAL_W'(out_ch.op));
        check_field("cell_row", VAL_W'(exp_cmd.row), VAL_W'(out_ch.cell_row));
        check_field("cell_column", VAL_W'(exp_cmd.col), VAL_W'(out_ch.cell_column));
        check_field("value", exp_cmd.value, out_ch.value);
        check_field("last", VAL_W'(exp_cmd.last), VAL_W'(out_ch.last));
      end
    end
  end

  // ---- tests ----

  task automatic test_directed();
    send_req(KIND_READ, rnd_data(), IDX_W'(IDX_MAX));
    send_req(KIND_CLEAR, rnd_data(), rnd_idx());
    send_req(KIND_SCAN, SC_BACKSPACE, rnd_idx());
    send_req(KIND_SCAN, SC_BACKSPACE | RELEASE_FLAG, rnd_idx());
    send_req(KIND_SCAN, SC_A, rnd_idx());
    send_req(KIND_SCAN, SC_A, rnd_idx());
    send_req(KIND_SCAN, SC_A | RELEASE_FLAG, rnd_idx());
    send_req(KIND_SCAN, SC_Q, rnd_idx());
    send_req(KIND_SCAN, SC_BACKSPACE, rnd_idx());
    send_req(KIND_SCAN, SC_CTRL, rnd_idx());
    send_req(KIND_SCAN, SC_UNMAPPED, rnd_idx());
    send_req(KIND_SCAN, SC_TOP_MAKE, rnd_idx());
    send_req(KIND_SCAN, SC_TOP_BREAK, rnd_idx());
    send_req(KIND_SCAN, SC_ENTER, rnd_idx());
    send_req(KIND_SCAN, SC_ENTER | RELEASE_FLAG, rnd_idx());
    send_req(KIND_READ, rnd_data(), '0);
    send_req(KIND_READ, rnd_data(), IDX_W'(1));
    send_req(KIND_PRINT, 8'h00, rnd_idx());
    send_req(KIND_PRINT, 8'hFF, rnd_idx());
    send_req(KIND_PRINT, CH_LF, rnd_idx());
    send_req(KIND_SCAN, SC_ESC, rnd_idx());
    send_req(KIND_SCAN, SC_SPACE, rnd_idx());
    send_req(KIND_SCAN, SC_BACKSPACE | RELEASE_FLAG, rnd_idx());
    send_req(KIND_SCAN, SC_Q | RELEASE_FLAG, rnd_idx());
    send_req(KIND_SCAN, SC_CTRL | RELEASE_FLAG, rnd_idx());
  endtask

  // fill the line past capacity across a column wrap, then back up to column 0 and try to go past it
  task automatic test_line_limit();
    send_req(KIND_CLEAR, rnd_data(), rnd_idx());
    type_key(SC_ENTER);
    repeat (20) send_req(KIND_PRINT, DATA_W'($urandom_range(8'h21, 8'h7E)), rnd_idx());
    repeat (70) type_key(pick_key());
    repeat (5) type_key(SC_BACKSPACE);
    type_key(SC_ENTER);
    for (int i = 0; i <= IDX_MAX; i++) send_req(KIND_READ, rnd_data(), IDX_W'(i));
  endtask

  // host text down to the last row, then scrolling from writes and enter
  task automatic test_screen_scroll();
    send_req(KIND_CLEAR, rnd_data(), rnd_idx());
    while (cur_row < SCREEN_ROWS - 1)
      send_req(KIND_PRINT, ($urandom_range(0, 4) == 0) ? CH_LF : rnd_data(), rnd_idx());
    repeat (30)
      send_req(KIND_PRINT, ($urandom_range(0, 6) == 0) ? CH_LF : rnd_data(), rnd_idx());
    repeat (5) type_key(pick_key());
    type_key(SC_ENTER);
    type_key(SC_ENTER);
    repeat (SCREEN_COLUMNS + 5) send_req(KIND_PRINT, rnd_data(), rnd_idx());
    repeat (3) type_key(pick_key());
  endtask

  task automatic test_random_traffic();
    int target;
    int sel;
    target = sent + 180;
    while (sent < target) begin
      sel = $urandom_range(0, 99);
      if (sel < 45)
        type_key(pick_key());
      else if (sel < 53)
        type_key(SC_BACKSPACE);
      else if (sel < 59)
        type_key(SC_ENTER);
      else if (sel < 72)
        send_req(KIND_PRINT, ($urandom_range(0, 5) == 0) ? CH_LF : rnd_data(), rnd_idx());
      else if (sel < 75)
        send_req(KIND_CLEAR, rnd_data(), rnd_idx());
      else if (sel < 87)
        send_req(KIND_READ, rnd_data(), rnd_idx());
      else
        send_req(KIND_SCAN, rnd_data(), rnd_idx());
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.kind       = '0;
    in_ch.data       = '0;
    in_ch.line_index = '0;
    errors           = 0;
    sent             = 0;
    burst_left       = 0;
    held_keys        = '0;
    line_len         = 0;
    done_len         = 0;
    cur_row          = 0;
    cur_col          = 0;
    foreach (typed_line[i]) typed_line[i] = '0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_line_limit();
    test_screen_scroll();
    test_random_traffic();

    @(negedge clk);
    in_ch.valid = 1'b0;
    wait (cmds_due.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (errors == 0 && cmds_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
